>>> hdl/hsv_to_rgb_converter_macros.svh
// assertion macros for the hsv to rgb converter
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HSV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define HSV_ASSERT_LAT(lbl, ante, cons, n, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

>>> hdl/hsv2rgb_pkg.sv
// types and constants for the hsv to rgb converter
// no dependencies
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } hsv_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_res_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYAN = 3'd2,
    SEC_CYAN_BLU = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_e;

  localparam int unsigned HUE_TURN   = 360;
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned PCT_MAX    = 100;
  // full scale of a term before the brightness product: 100 * 60
  localparam int unsigned TERM_FULL  = 6000;
  // channel = floor((17 * v * x + 20000) / 40000)
  localparam int unsigned RND_MUL    = 17;
  localparam int unsigned RND_OFS    = 20000;
  // 40000 = 64 * 625, divide by 625 through a reciprocal
  localparam int unsigned PRE_SHIFT  = 6;
  localparam int unsigned RECIP_K    = 28;
  localparam int unsigned RECIP_M    = 429497;
  localparam int unsigned LATENCY    = 5;

endpackage

>>> hdl/hsv_to_rgb_converter.sv
// hsv to rgb pixel converter, five register stages, one pixel per clock
// depends on hsv2rgb_pkg and hsv_to_rgb_converter_macros.svh
`timescale 1ns / 1ps
//
//  channel   direction  handshake        payload
//  request   in         start, busy      req_i (hue, saturation, brightness)
//  result    out        done_o strobe    res_o (red, green, blue)
//
//  a request is taken at every edge with start high; busy stays low
//  each result appears on res_o with done_o high once it has passed
//  the five pipeline stages: decode, term select,
//  brightness multiply, rounding offset, reciprocal multiply
//  reset clears only the stage valid bits; the pipeline never stalls

`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  hsv2rgb_pkg::hsv_req_t req_i,
  output logic                  done_o,
  output hsv2rgb_pkg::rgb_res_t res_o
);

  import hsv2rgb_pkg::*;

  // stage valid bits
  logic [LATENCY-1:0] vld_q;

  // stage 1: wrapped hue split into sector and remainder, clamped inputs
  logic [8:0] hue_w;
  sector_e    sec_d, sec_q;
  logic [5:0] rem_d, rem_q;
  logic [6:0] sat_d, sat_q;
  logic [6:0] val_d, val_q;

  // stage 2: per channel term (0..6000) and brightness
  logic [12:0] xp, xq, xt;
  logic [12:0] sq_prod, st_prod;
  logic [5:0]  rem_inv;
  logic [2:0][12:0] x_d, x_q;
  logic [6:0]  val2_q;

  // stage 3: brightness times term
  logic [2:0][19:0] prod_q;

  // stage 4: rounding offset and pre shift
  logic [2:0][23:0] num_w;
  logic [2:0][17:0] n_q;

  // stage 5: reciprocal multiply
  logic [2:0][36:0] rq_w;
  rgb_res_t         res_q;

  assign busy = 1'b0;

  always_comb begin
    if (req_i.hue >= 9'(HUE_TURN)) begin
      hue_w = req_i.hue - 9'(HUE_TURN);
    end else begin
      hue_w = req_i.hue;
    end
    sat_d = (req_i.saturation > 7'(PCT_MAX)) ? 7'(PCT_MAX) : req_i.saturation;
    val_d = (req_i.brightness > 7'(PCT_MAX)) ? 7'(PCT_MAX) : req_i.brightness;
    if (hue_w >= 9'(5 * SECTOR_DEG)) begin
      sec_d = SEC_MAG_RED;
      rem_d = 6'(hue_w - 9'(5 * SECTOR_DEG));
    end else if (hue_w >= 9'(4 * SECTOR_DEG)) begin
      sec_d = SEC_BLU_MAG;
      rem_d = 6'(hue_w - 9'(4 * SECTOR_DEG));
    end else if (hue_w >= 9'(3 * SECTOR_DEG)) begin
      sec_d = SEC_CYAN_BLU;
      rem_d = 6'(hue_w - 9'(3 * SECTOR_DEG));
    end else if (hue_w >= 9'(2 * SECTOR_DEG)) begin
      sec_d = SEC_GRN_CYAN;
      rem_d = 6'(hue_w - 9'(2 * SECTOR_DEG));
    end else if (hue_w >= 9'(SECTOR_DEG)) begin
      sec_d = SEC_YEL_GRN;
      rem_d = 6'(hue_w - 9'(SECTOR_DEG));
    end else begin
      sec_d = SEC_RED_YEL;
      rem_d = 6'(hue_w);
    end
  end

  // p, q and t terms, all scaled by 6000
  always_comb begin
    rem_inv = 6'(SECTOR_DEG) - rem_q;
    xp      = 13'(7'(PCT_MAX) - sat_q) * 13'(SECTOR_DEG);
    sq_prod = 13'(sat_q) * 13'(rem_q);
    st_prod = 13'(sat_q) * 13'(rem_inv);
    xq      = 13'(TERM_FULL) - sq_prod;
    xt      = 13'(TERM_FULL) - st_prod;
    case (sec_q)
      SEC_RED_YEL:  x_d = {13'(TERM_FULL), xt, xp};
      SEC_YEL_GRN:  x_d = {xq, 13'(TERM_FULL), xp};
      SEC_GRN_CYAN: x_d = {xp, 13'(TERM_FULL), xt};
      SEC_CYAN_BLU: x_d = {xp, xq, 13'(TERM_FULL)};
      SEC_BLU_MAG:  x_d = {xt, xp, 13'(TERM_FULL)};
      default:      x_d = {13'(TERM_FULL), xp, xq};
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_w[i] = 24'(prod_q[i]) * 24'(RND_MUL) + 24'(RND_OFS);
      rq_w[i]  = 37'(n_q[i]) * 37'(RECIP_M);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= sec_d;
    rem_q  <= rem_d;
    sat_q  <= sat_d;
    val_q  <= val_d;
    x_q    <= x_d;
    val2_q <= val_q;
    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= 20'(val2_q) * 20'(x_q[i]);
      n_q[i]    <= 18'(num_w[i] >> PRE_SHIFT);
    end
    res_q.red   <= rq_w[2][RECIP_K+7:RECIP_K];
    res_q.green <= rq_w[1][RECIP_K+7:RECIP_K];
    res_q.blue  <= rq_w[0][RECIP_K+7:RECIP_K];
  end

  assign done_o = vld_q[LATENCY-1];
  assign res_o  = res_q;

  `HSV_ASSERT_LAT(a_req_gives_result, start, done_o, 5, "request did not produce a result")
  `HSV_ASSERT_LAT(a_no_phantom, !start, !done_o, 5, "result without a request")
  `HSV_ASSERT_SAME(a_full_term, vld_q[1],
    x_q[0] == 13'(TERM_FULL) || x_q[1] == 13'(TERM_FULL) || x_q[2] == 13'(TERM_FULL),
    "no channel carries the full value term")
  `HSV_ASSERT_LAT(a_grey, vld_q[0] && sat_q == '0,
    x_q[0] == x_q[1] && x_q[1] == x_q[2], 1, "zero saturation is not grey")

endmodule
